// ===== design/iso_date_sort_key_defines.svh =====
// Assertion macros shared by the date key design.
`ifndef ISO_DATE_SORT_KEY_DEFINES_SVH
`define ISO_DATE_SORT_KEY_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property while out of reset.
`define ISODK_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("isodk assertion failed");

// Check a property at every edge, reset included.
`define ISODK_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("isodk assertion failed");

`else

`define ISODK_ASSERT(name, clk, rst_n, prop)
`define ISODK_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// ===== design/isodk_pkg.sv =====
`timescale 1ns / 1ps

package isodk_pkg;

    // Field and state widths
    localparam int CHAR_W  = 8;
    localparam int KEY_W   = 27;
    localparam int POS_W   = 4;
    localparam int YEAR_W  = 14;
    localparam int MD_W    = 7;
    localparam int DIGIT_W = 4;
    localparam int MDAY_W  = 5;

    // Characters
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_DASH = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_T    = 8'h54;

    // Character positions within the string
    localparam logic [POS_W-1:0] POS_YEAR_0 = 4'd0;
    localparam logic [POS_W-1:0] POS_YEAR_1 = 4'd1;
    localparam logic [POS_W-1:0] POS_YEAR_2 = 4'd2;
    localparam logic [POS_W-1:0] POS_YEAR_3 = 4'd3;
    localparam logic [POS_W-1:0] POS_SEP_1  = 4'd4;
    localparam logic [POS_W-1:0] POS_MON_LO = 4'd5;
    localparam logic [POS_W-1:0] POS_MON_HI = 4'd6;
    localparam logic [POS_W-1:0] POS_SEP_2  = 4'd7;
    localparam logic [POS_W-1:0] POS_DAY_LO = 4'd8;
    localparam logic [POS_W-1:0] POS_DAY_HI = 4'd9;
    localparam logic [POS_W-1:0] POS_TIME   = 4'd10;
    localparam logic [POS_W-1:0] POS_SAT    = 4'd11;

    // Arithmetic constants
    localparam logic [DIGIT_W-1:0] DEC_BASE    = 4'd10;
    localparam logic [MD_W-1:0]    MONTH_MAX   = 7'd12;
    localparam logic [MD_W-1:0]    MONTH_FEB   = 7'd2;
    localparam logic [YEAR_W-1:0]  YEAR_SCALE  = 14'd10000;
    localparam logic [MD_W-1:0]    MONTH_SCALE = 7'd100;
    localparam logic [KEY_W-1:0]   KEY_MIN     = 27'd10000;
    localparam logic [KEY_W-1:0]   KEY_MAX     = 27'd99991231;

    // Parsed string, handed from the parser to the key stage
    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MD_W-1:0]   month;
        logic [MD_W-1:0]   day;
        logic              has_month;
        logic              has_day;
        logic              century;   // last two year digits are zero
        logic              bad;       // format, length, year or month fault
    } t_fin;

    // Days in a common year for a month in 1..12
    function automatic logic [MDAY_W-1:0] month_days(input logic [MD_W-1:0] month);
        logic [MDAY_W-1:0] days;
        if (month == MONTH_FEB) begin
            days = 5'd28;
        end else if (month inside {7'd4, 7'd6, 7'd9, 7'd11}) begin
            days = 5'd30;
        end else begin
            days = 5'd31;
        end
        return days;
    endfunction

endpackage

// ===== design/isodk_char_if.sv =====
`timescale 1ns / 1ps

interface isodk_char_if;
    import isodk_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== design/isodk_key_if.sv =====
`timescale 1ns / 1ps

interface isodk_key_if;
    import isodk_pkg::*;

    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] date_key;

    modport source (output valid, output date_key, input ready);
    modport sink   (input valid, input date_key, output ready);
endinterface

// ===== design/isodk_parse.sv =====
`timescale 1ns / 1ps
`include "iso_date_sort_key_defines.svh"

module isodk_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    isodk_char_if.sink        i_char,
    output logic              o_fin_valid,
    output isodk_pkg::t_fin   o_fin,
    input  logic              i_fin_take
);
    import isodk_pkg::*;

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;

    logic [POS_W-1:0]  r_pos;
    logic [YEAR_W-1:0] r_year;
    logic [MD_W-1:0]   r_month;
    logic [MD_W-1:0]   r_day;
    logic              r_cent;
    logic              r_err;

    logic [POS_W-1:0]  n_pos;
    logic [YEAR_W-1:0] n_year;
    logic [MD_W-1:0]   n_month;
    logic [MD_W-1:0]   n_day;
    logic              n_cent;
    logic              n_err;

    logic              r_fin_valid;
    t_fin              r_fin;
    t_fin              n_fin;

    logic              w_fin_free;
    logic              w_go;
    logic              w_in_free;
    logic              w_is_digit;
    logic [CHAR_W-1:0] w_char_off;
    logic [DIGIT_W-1:0] w_digit;
    logic              w_len_ok;

    // Handshake: a final item needs room in the parsed-string slot
    assign w_fin_free   = !r_fin_valid || i_fin_take;
    assign w_go         = r_in_valid && (!r_last || w_fin_free);
    assign w_in_free    = !r_in_valid || w_go;
    assign i_char.ready = w_in_free;

    // Capture the incoming item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_free) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_free && i_char.valid) begin
            r_char <= i_char.char_code;
            r_last <= i_char.last_char;
        end
    end

    // Classify the character
    assign w_is_digit = (r_char >= CHAR_ZERO) && (r_char <= CHAR_NINE);
    assign w_char_off = r_char - CHAR_ZERO;
    assign w_digit    = w_char_off[DIGIT_W-1:0];

    // Check the character against its position and accumulate digits
    always_comb begin
        n_year  = r_year;
        n_month = r_month;
        n_day   = r_day;
        n_cent  = r_cent;
        n_err   = r_err;
        n_pos   = (r_pos == POS_SAT) ? r_pos : r_pos + 1'b1;
        case (r_pos)
            POS_YEAR_0, POS_YEAR_1, POS_YEAR_2, POS_YEAR_3: begin
                if (!w_is_digit) begin
                    n_err = 1'b1;
                end else begin
                    n_year = YEAR_W'(r_year * YEAR_W'(DEC_BASE) + YEAR_W'(w_digit));
                    if (r_pos == POS_YEAR_2) begin
                        n_cent = (w_digit == '0);
                    end else if (r_pos == POS_YEAR_3) begin
                        n_cent = r_cent && (w_digit == '0);
                    end
                end
            end
            POS_MON_LO, POS_MON_HI: begin
                if (!w_is_digit) begin
                    n_err = 1'b1;
                end else begin
                    n_month = MD_W'(r_month * MD_W'(DEC_BASE) + MD_W'(w_digit));
                end
            end
            POS_DAY_LO, POS_DAY_HI: begin
                if (!w_is_digit) begin
                    n_err = 1'b1;
                end else begin
                    n_day = MD_W'(r_day * MD_W'(DEC_BASE) + MD_W'(w_digit));
                end
            end
            POS_SEP_1, POS_SEP_2: begin
                if (r_char != CHAR_DASH) begin
                    n_err = 1'b1;
                end
            end
            POS_TIME: begin
                if (r_char != CHAR_T) begin
                    n_err = 1'b1;
                end
            end
            default: begin
                n_err = r_err;
            end
        endcase
    end

    // Judge the string as it stands after its final character
    assign w_len_ok = (r_pos == POS_YEAR_3) || (r_pos == POS_MON_HI) || (r_pos >= POS_DAY_HI);

    always_comb begin
        n_fin.year      = n_year;
        n_fin.month     = n_month;
        n_fin.day       = n_day;
        n_fin.has_month = (r_pos >= POS_MON_HI);
        n_fin.has_day   = (r_pos >= POS_DAY_HI);
        n_fin.century   = n_cent;
        n_fin.bad       = n_err || !w_len_ok || (n_year == '0)
                        || (n_fin.has_month && ((n_month == '0) || (n_month > MONTH_MAX)));
    end

    // Advance the string state; clear it after the final character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_year  <= '0;
            r_month <= '0;
            r_day   <= '0;
            r_cent  <= 1'b0;
            r_err   <= 1'b0;
        end else if (w_go) begin
            if (r_last) begin
                r_pos   <= '0;
                r_year  <= '0;
                r_month <= '0;
                r_day   <= '0;
                r_cent  <= 1'b0;
                r_err   <= 1'b0;
            end else begin
                r_pos   <= n_pos;
                r_year  <= n_year;
                r_month <= n_month;
                r_day   <= n_day;
                r_cent  <= n_cent;
                r_err   <= n_err;
            end
        end
    end

    // Hold the parsed string until the key stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (w_go && r_last) begin
            r_fin_valid <= 1'b1;
        end else if (i_fin_take) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && r_last) begin
            r_fin <= n_fin;
        end
    end

    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

    `ISODK_ASSERT(a_pos_saturates, i_clk, i_rst_n, r_pos <= POS_SAT)
    `ISODK_ASSERT(a_clear_after_last, i_clk, i_rst_n, (w_go && r_last) |=> ((r_pos == '0) && !r_err && (r_year == '0)))
    `ISODK_ASSERT(a_fin_held, i_clk, i_rst_n, (r_fin_valid && !i_fin_take) |=> (r_fin_valid && $stable(r_fin)))

endmodule

// ===== design/iso_date_sort_key.sv =====
`timescale 1ns / 1ps
`include "iso_date_sort_key_defines.svh"

// ISO 8601 date string to YYYYMMDD sort key. Characters enter one per cycle on
// i_char as ready allows, with last_char set on the final one; for each string exactly one
// key leaves on o_key, year*10000 + month*100 + day, with an absent month or
// day as zero and 0 for a malformed string. Accepted forms are YYYY, YYYY-MM
// and YYYY-MM-DD optionally followed by 'T' and anything. The block takes one
// character every cycle unless a final character waits for room in the
// parsed-string register; a key passes from the input register through the
// parsed-string register to the key register, which takes the key formed
// from the year*10000 product and the day check. A stalled output still lets
// a further string be parsed up to its final character.
module iso_date_sort_key (
    input  logic        i_clk,
    input  logic        i_rst_n,
    isodk_char_if.sink  i_char,
    isodk_key_if.source o_key
);
    import isodk_pkg::*;

    logic              w_fin_valid;
    t_fin              w_fin;
    logic              w_out_free;

    logic              r_out_valid;
    logic [KEY_W-1:0]  r_key;
    logic [KEY_W-1:0]  n_key;

    logic              w_leap;
    logic [MDAY_W-1:0] w_max_day;
    logic              w_bad;
    logic [MD_W-1:0]   w_month;
    logic [MD_W-1:0]   w_day;

    // Parse characters and accumulate fields
    isodk_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char      (i_char),
        .o_fin_valid (w_fin_valid),
        .o_fin       (w_fin),
        .i_fin_take  (w_out_free)
    );

    assign w_out_free = !r_out_valid || o_key.ready;

    // Check the day against the month, with the Gregorian leap rule
    assign w_leap    = (w_fin.year[1:0] == '0) && (!w_fin.century || (w_fin.year[3:0] == '0));
    assign w_max_day = month_days(w_fin.month) + MDAY_W'(w_leap && (w_fin.month == MONTH_FEB));
    assign w_bad     = w_fin.bad
                     || (w_fin.has_day && ((w_fin.day == '0)
                                           || (w_fin.day > MD_W'(w_max_day))));

    // Form the key
    assign w_month = w_fin.has_month ? w_fin.month : '0;
    assign w_day   = w_fin.has_day ? w_fin.day : '0;
    assign n_key   = w_bad ? '0
                   : KEY_W'(w_fin.year) * KEY_W'(YEAR_SCALE)
                     + KEY_W'(w_month) * KEY_W'(MONTH_SCALE)
                     + KEY_W'(w_day);

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_fin_valid) begin
            r_key <= n_key;
        end
    end

    assign o_key.valid    = r_out_valid;
    assign o_key.date_key = r_key;

    `ISODK_ASSERT(a_key_range, i_clk, i_rst_n, (r_out_valid && (r_key != '0)) |-> ((r_key >= KEY_MIN) && (r_key <= KEY_MAX)))
    `ISODK_ASSERT(a_fin_not_lost, i_clk, i_rst_n, (w_fin_valid && w_out_free) |=> r_out_valid)
    `ISODK_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !r_out_valid)

endmodule

// ===== sim/iso_date_sort_key_test.sv =====
`timescale 1ns / 1ps

module iso_date_sort_key_test;
    import isodk_pkg::*;

    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_CHARS  = 155;

    // Parse each date string as it is accepted and queue the key it should give
    class date_key_board;
        logic [POS_W-1:0]  pos;
        logic [YEAR_W-1:0] year;
        logic [MD_W-1:0]   month;
        logic [MD_W-1:0]   day;
        bit                fmt_bad;
        logic [KEY_W-1:0]  keys_due[$];
        int                errors;
        int unsigned       days_in[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            pos     = POS_YEAR_0;
            year    = '0;
            month   = '0;
            day     = '0;
            fmt_bad = 1'b0;
        endfunction

        function void note_char(logic [CHAR_W-1:0] c, logic last);
            logic [POS_W-1:0]   p;
            logic [DIGIT_W-1:0] d;
            bit                 digit;
            bit                 bad;
            bit                 has_month;
            bit                 has_day;
            bit                 leap;
            int unsigned        maxd;
            logic [KEY_W-1:0]   key;
            p     = pos;
            digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
            d     = DIGIT_W'(c - CHAR_ZERO);
            // check the character against its position and accumulate digits
            case (p)
                POS_YEAR_0, POS_YEAR_1, POS_YEAR_2, POS_YEAR_3: begin
                    if (!digit) fmt_bad = 1'b1;
                    else year = year * DEC_BASE + d;
                end
                POS_MON_LO, POS_MON_HI: begin
                    if (!digit) fmt_bad = 1'b1;
                    else month = month * DEC_BASE + d;
                end
                POS_DAY_LO, POS_DAY_HI: begin
                    if (!digit) fmt_bad = 1'b1;
                    else day = day * DEC_BASE + d;
                end
                POS_SEP_1, POS_SEP_2: begin
                    if (c != CHAR_DASH) fmt_bad = 1'b1;
                end
                POS_TIME: begin
                    if (c != CHAR_T) fmt_bad = 1'b1;
                end
                default: ;
            endcase
            if (pos != POS_SAT) pos = pos + 1'b1;
            if (!last) return;

            // judge the whole string on its final character
            has_day   = (p >= POS_DAY_HI);
            has_month = has_day || (p == POS_MON_HI);
            bad       = fmt_bad || !(has_month || p == POS_YEAR_3) || (year == 0);
            if (has_month && (month < 1 || month > MONTH_MAX)) bad = 1'b1;
            if (!bad && has_day) begin
                leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
                maxd = days_in[month - 1];
                if (month == MONTH_FEB && leap) maxd++;
                if (day < 1 || day > maxd) bad = 1'b1;
            end
            if (bad) key = '0;
            else key = KEY_W'(year * 10000 + (has_month ? month : 0) * 100
                              + (has_day ? day : 0));
            keys_due.push_back(key);
            restart();
        endfunction

        function void check_key(logic [KEY_W-1:0] got);
            logic [KEY_W-1:0] want;
            if (keys_due.size() == 0) begin
                $display("%0t: date_key with none due: expected nothing, actual %0d",
                         $time, got);
                errors++;
                return;
            end
            want = keys_due.pop_front();
            if (got !== want) begin
                $display("%0t: date_key mismatch: expected %0d, actual %0d",
                         $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    isodk_char_if char_ch();
    isodk_key_if  key_ch();

    iso_date_sort_key DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_ch),
        .o_key   (key_ch)
    );

    date_key_board     board = new();
    logic [CHAR_W-1:0] date_chars[$];
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                hold_req       = 0;
    int                hold_seen      = 0;
    int                hold_left      = 0;
    int                stall_run      = 0;
    int                chars_sent     = 0;

    // Clock: 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Drive ready: long hold-off on request, else random stalls
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen    <= hold_req;
            hold_left    <= HOLD_CYCLES;
            key_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            key_ch.ready <= 1'b0;
        end else begin
            key_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Note accepted characters, check keys, and watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (char_ch.valid && char_ch.ready) begin
                board.note_char(char_ch.char_code, char_ch.last_char);
            end
            if (key_ch.valid && key_ch.ready) begin
                board.check_key(key_ch.date_key);
            end
            if ((char_ch.valid && char_ch.ready) || (key_ch.valid && key_ch.ready)) begin
                stall_run <= 0;
            end else if (stall_run + 1 >= STALL_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("iso_date_sort_key_test: done, errors");
                $finish;
            end else begin
                stall_run <= stall_run + 1;
            end
        end
    end

    // Offer one character, with random gaps, and hold it until taken
    task automatic drive_char(logic [CHAR_W-1:0] c, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            char_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= c;
        char_ch.last_char <= last;
        do @(posedge i_clk); while (!char_ch.ready);
        chars_sent++;
    endtask

    task automatic send_date();
        foreach (date_chars[i]) drive_char(date_chars[i], i == date_chars.size() - 1);
    endtask

    task automatic load_text(string s);
        date_chars.delete();
        foreach (s[i]) date_chars.push_back(s[i]);
    endtask

    task automatic push_digits(int value, int count);
        int scale;
        scale = 1;
        repeat (count - 1) scale *= 10;
        while (scale > 0) begin
            date_chars.push_back(CHAR_W'(CHAR_ZERO + (value / scale) % 10));
            scale /= 10;
        end
    endtask

    // Well-formed layout with random content, biased to the edges of the calendar
    task automatic build_date();
        int yr;
        int mo;
        int dy;
        int tail;
        date_chars.delete();
        case ($urandom_range(9))
            0: yr = 0;
            1: yr = 100 * $urandom_range(1, 99);
            2: yr = 4 * $urandom_range(1, 2499);
            3: yr = 9999;
            default: yr = $urandom_range(1, 9999);
        endcase
        case ($urandom_range(9))
            0: mo = $urandom_range(0, 99);
            1, 2: mo = MONTH_FEB;
            default: mo = $urandom_range(1, 12);
        endcase
        case ($urandom_range(7))
            0: dy = $urandom_range(0, 99);
            1, 2: dy = $urandom_range(28, 31);
            default: dy = $urandom_range(1, 28);
        endcase
        push_digits(yr, 4);
        case ($urandom_range(3))
            0: ;
            1: begin
                date_chars.push_back(CHAR_DASH);
                push_digits(mo, 2);
            end
            default: begin
                date_chars.push_back(CHAR_DASH);
                push_digits(mo, 2);
                date_chars.push_back(CHAR_DASH);
                push_digits(dy, 2);
                // optional time marker and a tail that must be ignored
                if ($urandom_range(1)) begin
                    if ($urandom_range(3) != 0) date_chars.push_back(CHAR_T);
                    else date_chars.push_back(CHAR_W'($urandom_range(255)));
                    tail = $urandom_range(0, 5);
                    repeat (tail) date_chars.push_back(CHAR_W'($urandom_range(255)));
                end
            end
        endcase
    endtask

    // Mostly well-formed strings; the rest corrupted, truncated or pure noise
    task automatic build_random_string();
        int n;
        int kind;
        kind = $urandom_range(19);
        if (kind < 14) begin
            build_date();
        end else if (kind < 17) begin
            build_date();
            if ($urandom_range(1)) begin
                date_chars[$urandom_range(date_chars.size() - 1)] =
                    CHAR_W'($urandom_range(255));
            end else begin
                n = $urandom_range(1, date_chars.size());
                while (date_chars.size() > n) void'(date_chars.pop_back());
            end
        end else begin
            date_chars.delete();
            n = $urandom_range(1, 14);
            repeat (n) begin
                case ($urandom_range(3))
                    0: date_chars.push_back(CHAR_W'(CHAR_ZERO + $urandom_range(9)));
                    1: date_chars.push_back(CHAR_DASH);
                    2: date_chars.push_back(CHAR_T);
                    default: date_chars.push_back(CHAR_W'($urandom_range(255)));
                endcase
            end
        end
    endtask

    initial begin
        int phase;
        int phase_end;
        char_ch.valid     = 1'b0;
        char_ch.char_code = '0;
        char_ch.last_char = 1'b0;
        key_ch.ready      = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: largest key with time marker and top byte in the tail
        load_text("9999-12-31T");
        date_chars.push_back(8'hFF);
        send_date();
        // year zero
        load_text("0000");
        send_date();
        // a lone NUL: non-digit and a bad length
        date_chars = '{8'h00};
        send_date();
        // century rule: 1900 is not a leap year, 2000 is
        load_text("1900-02-29");
        send_date();
        load_text("2000-02-29");
        send_date();

        // Random strings under each idling pattern
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct  = 53;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 53;
                end
                default: begin
                    send_idle_pct  = 29;
                    recv_stall_pct <= 29;
                end
            endcase
            // hold the key side off so the block fills and backs up its input
            if (phase == 0) hold_req <= hold_req + 1;
            phase_end = chars_sent + PHASE_CHARS;
            while (chars_sent < phase_end) begin
                build_random_string();
                send_date();
            end
            // pause until every key due has come out
            char_ch.valid <= 1'b0;
            do @(posedge i_clk); while (board.keys_due.size() != 0);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.keys_due.size() == 0) begin
            $display("iso_date_sort_key_test: done, clean");
        end else begin
            $display("iso_date_sort_key_test: done, errors");
        end
        $finish;
    end

endmodule
